// ===== sv/hsid_pkg.sv =====
// Shared types and constants for the hash set insert/delete block.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsid_pkg;

  // Field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 3;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_PRESENT   = 3'd1,
    STAT_DELETED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_COMMIT
  } fsm_e;

endpackage : hsid_pkg

`default_nettype wire

// ===== sv/hsid_rem.sv =====
// Bucket index unit: key modulo the bucket count.
// Power-of-two counts take the low bits; others use a scaled reciprocal
// multiply and one compare/subtract, registered in q_q, r_q and rem_q. Depends on hsid_pkg.
`default_nettype none

module hsid_rem #(
  parameter int unsigned BUCKETS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [hsid_pkg::KEY_W-1:0]     dividend_i,
  output logic                                done_o,
  output logic [$clog2(BUCKETS)-1:0]          rem_o
);
  import hsid_pkg::*;

  localparam int unsigned BKT_W = $clog2(BUCKETS);
  localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  if (IS_POW2) begin : g_pow2
    logic             done_q;
    logic [BKT_W-1:0] rem_q;

    // Low bits are the remainder
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= dividend_i[BKT_W-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    localparam int unsigned SHIFT  = KEY_W + BKT_W;
    localparam int unsigned PROD_W = KEY_W + 32;
    localparam int unsigned Q_W    = PROD_W - SHIFT;
    localparam int unsigned R_W    = BKT_W + 1;
    // floor(2^SHIFT / BUCKETS) fits 32 bits since BUCKETS > 2^(BKT_W-1)
    localparam logic [31:0] MAGIC  = 32'((64'd1 << SHIFT) / 64'(BUCKETS));

    logic              v1_q, v2_q, v3_q, done_q;
    logic [KEY_W-1:0]  key_q;
    logic [Q_W-1:0]    q_q, q_d;
    logic [R_W-1:0]    r_q, r_d;
    logic [BKT_W-1:0]  rem_q, rem_d;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  qd;
    logic [KEY_W-1:0]  diff;

    // Quotient estimate from the reciprocal: true quotient or one below
    always_comb begin
      prod = PROD_W'(key_q) * PROD_W'(MAGIC);
      q_d  = prod[PROD_W-1:SHIFT];
    end

    // Remainder estimate, below twice the bucket count
    always_comb begin
      qd   = KEY_W'(q_q) * KEY_W'(BUCKETS);
      diff = key_q - qd;
      r_d  = diff[R_W-1:0];
    end

    // Final compare and subtract
    always_comb begin
      rem_d = (r_q >= R_W'(BUCKETS)) ? BKT_W'(r_q - R_W'(BUCKETS)) : r_q[BKT_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q   <= 1'b0;
        v2_q   <= 1'b0;
        v3_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        v1_q   <= start_i;
        v2_q   <= v1_q;
        v3_q   <= v2_q;
        done_q <= v3_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= dividend_i;
      end
      q_q   <= q_d;
      r_q   <= r_d;
      rem_q <= rem_d;
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule : hsid_rem

`default_nettype wire

// ===== sv/hsid_mem.sv =====
// Slot storage: key memory (one key per slot) and valid-row memory
// (one WAYS-bit row per bucket) with a clearing pass after reset.
// Depends on hsid_pkg.
`default_nettype none

module hsid_mem #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  output logic                                      clearing_o,
  // key memory
  input  wire logic [$clog2(BUCKETS*WAYS)-1:0]      key_rd_addr_i,
  output logic [hsid_pkg::KEY_W-1:0]                key_rd_data_o,
  input  wire logic                                 key_we_i,
  input  wire logic [$clog2(BUCKETS*WAYS)-1:0]      key_wr_addr_i,
  input  wire logic [hsid_pkg::KEY_W-1:0]           key_wr_data_i,
  // valid-row memory
  input  wire logic [$clog2(BUCKETS)-1:0]           row_addr_i,
  output logic [WAYS-1:0]                           row_rd_data_o,
  input  wire logic                                 row_we_i,
  input  wire logic [WAYS-1:0]                      row_wr_data_i
);
  import hsid_pkg::*;

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOTS  = BUCKETS * WAYS;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [WAYS-1:0]  row_mem [BUCKETS];

  logic             clr_q, clr_d;
  logic [BKT_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             row_we;
  logic [BKT_W-1:0] row_wr_addr;
  logic [WAYS-1:0]  row_wr_data;

  // Clearing pass: one row per cycle after reset
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + BKT_W'(1);
      if (clr_cnt_q == BKT_W'(BUCKETS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Row write port shared between clearing and commits
  always_comb begin
    row_we      = clr_q | row_we_i;
    row_wr_addr = clr_q ? clr_cnt_q : row_addr_i;
    row_wr_data = clr_q ? '0 : row_wr_data_i;
  end

  // Key memory, registered read
  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[key_wr_addr_i] <= key_wr_data_i;
    end
    key_rd_data_o <= key_mem[key_rd_addr_i];
  end

  // Valid-row memory, registered read
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wr_addr] <= row_wr_data;
    end
    row_rd_data_o <= row_mem[row_addr_i];
  end

  assign clearing_o = clr_q;

endmodule : hsid_mem

`default_nettype wire

// ===== sv/hash_set_insert_delete.sv =====
// Hash set insert/delete, BUCKETS buckets of WAYS slots, bucket = key mod BUCKETS.
// Each request passes the remainder unit (low bits when BUCKETS is a power of two, a
// reciprocal multiply otherwise), a scan of the bucket and a commit; busy_o drops in the
// done_o cycle, so a new request is accepted in that cycle at the earliest. The scan reads the
// single key-memory read port one way per cycle. done_o is a one-cycle strobe; the
// receiver cannot stall. After reset busy_o is high while the valid rows are cleared.
`default_nettype none

module hash_set_insert_delete #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            command_i,
  input  wire logic [hsid_pkg::KEY_W-1:0]      key_i,
  output logic                                 done_o,
  output logic [hsid_pkg::STATUS_W-1:0]        status_o
);
  import hsid_pkg::*;

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = $clog2(BUCKETS * WAYS);
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);

  fsm_e             state_q, state_d;
  logic             cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [BKT_W-1:0] bucket_q, bucket_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             hit_q, hit_d;
  logic [WAY_W-1:0] hit_way_q, hit_way_d;
  logic             free_q, free_d;
  logic [WAY_W-1:0] free_way_q, free_way_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;

  logic             accept;
  logic             rem_done;
  logic [BKT_W-1:0] rem;
  logic             clearing;
  logic [KEY_W-1:0] key_rd_data;
  logic [WAYS-1:0]  row_rd_data;
  logic             key_we;
  logic             row_we;
  logic [WAYS-1:0]  row_wr_data;
  logic [SLOT_W-1:0] slot_base;
  logic [SLOT_W-1:0] key_rd_addr;
  logic [SLOT_W-1:0] key_wr_addr;
  logic [CNT_W-1:0] ev_cnt;
  logic [WAY_W-1:0] ev_way;

  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != ST_IDLE) | clearing;

  // Bucket index unit
  hsid_rem #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (key_i),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Slot addressing
  assign slot_base   = SLOT_W'(bucket_q) * SLOT_W'(WAYS);
  assign key_rd_addr = slot_base + SLOT_W'(cnt_q[WAY_W-1:0]);
  assign key_wr_addr = slot_base + SLOT_W'(free_way_q);
  assign ev_cnt      = cnt_q - CNT_W'(1);
  assign ev_way      = ev_cnt[WAY_W-1:0];

  hsid_mem #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clearing_o    (clearing),
    .key_rd_addr_i (key_rd_addr),
    .key_rd_data_o (key_rd_data),
    .key_we_i      (key_we),
    .key_wr_addr_i (key_wr_addr),
    .key_wr_data_i (key_q),
    .row_addr_i    (bucket_q),
    .row_rd_data_o (row_rd_data),
    .row_we_i      (row_we),
    .row_wr_data_i (row_wr_data)
  );

  // Sequencer: hash, scan ways, commit
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    bucket_d   = bucket_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    hit_way_d  = hit_way_q;
    free_d     = free_q;
    free_way_d = free_way_q;
    done_d     = 1'b0;
    status_d   = status_q;
    key_we     = 1'b0;
    row_we     = 1'b0;
    row_wr_data = row_rd_data;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          key_d   = key_i;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (rem_done) begin
          bucket_d = rem;
          cnt_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read of way cnt issued now; data of way cnt-1 checked now
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q != '0) begin
          if (row_rd_data[ev_way]) begin
            if (!hit_q && key_rd_data == key_q) begin
              hit_d     = 1'b1;
              hit_way_d = ev_way;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_way_d = ev_way;
          end
        end
        if (cnt_q == CNT_W'(WAYS)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_INSERT) begin
          if (hit_q) begin
            status_d = STAT_PRESENT;
          end else if (free_q) begin
            key_we              = 1'b1;
            row_we              = 1'b1;
            row_wr_data[free_way_q] = 1'b1;
            status_d            = STAT_INSERTED;
          end else begin
            status_d = STAT_FULL;
          end
        end else begin
          if (hit_q) begin
            row_we                 = 1'b1;
            row_wr_data[hit_way_q] = 1'b0;
            status_d               = STAT_DELETED;
          end else begin
            status_d = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    bucket_q   <= bucket_d;
    cnt_q      <= cnt_d;
    hit_q      <= hit_d;
    hit_way_q  <= hit_way_d;
    free_q     <= free_d;
    free_way_q <= free_way_d;
    status_q   <= status_d;
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule : hash_set_insert_delete

`default_nettype wire
